// ===== rtl/core/degenerate_dna_site_scanner_defines.svh =====
// Assertion macros for the degenerate DNA site scanner.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef DEGENERATE_DNA_SITE_SCANNER_DEFINES_SVH
`define DEGENERATE_DNA_SITE_SCANNER_DEFINES_SVH
`ifndef SYNTH
`define DDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DDS_ASSERT_IMP(lbl, ante, cons, msg)
`define DDS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/dds_pkg.sv =====
// Shared types and constants of the degenerate DNA site scanner.
// No dependencies.
`default_nettype none
package dds_pkg;
  localparam int unsigned PATTERN_MAX_DEF   = 16;
  localparam int unsigned POSITION_BITS_DEF = 32;
  localparam int unsigned BASE_W            = 2;
  localparam int unsigned MASK_W            = 4;
  localparam int unsigned MASKS_W           = 64;
  localparam int unsigned LEN_W             = 5;
  localparam int unsigned OUT_W             = 32;
  localparam int unsigned CFG_IDX_W         = 1;
  localparam int unsigned CFG_DATA_W        = 64;
  localparam int unsigned QUEUE_DEPTH       = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 1'b0,
    CFG_PATTERN_MASKS  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic             hit;
    logic [OUT_W-1:0] site_start;
  } match_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;
endpackage
`default_nettype wire

// ===== rtl/core/dds_if.sv =====
// Request channels of the site scanner: base input and match result.
// Depends on dds_pkg.
`default_nettype none
interface dds_in_if;
  logic                         valid;
  logic                         ready;
  logic [dds_pkg::BASE_W-1:0]   base;
  logic                         restart;
  modport source (output valid, output base, output restart, input ready);
  modport sink (input valid, input base, input restart, output ready);
endinterface

interface dds_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [dds_pkg::OUT_W-1:0]    site_start;
  logic [dds_pkg::OUT_W-1:0]    hit_index;
  modport source (output valid, output hit, output site_start, output hit_index, input ready);
  modport sink (input valid, input hit, input site_start, input hit_index, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dds_front.sv =====
// Front end: config registers, base window, position counter, pattern compare.
// Depends on dds_pkg and dds_if.
`default_nettype none
module dds_front #(
  parameter int unsigned PATTERN_MAX   = dds_pkg::PATTERN_MAX_DEF,
  parameter int unsigned POSITION_BITS = dds_pkg::POSITION_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [dds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [dds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  dds_in_if.sink                              in_i,
  input  wire logic                           full_i,
  output logic                                push_o,
  output dds_pkg::match_t                     push_data_o
);
  localparam int unsigned LEN_W  = dds_pkg::LEN_W;
  localparam int unsigned FILL_W = $clog2(PATTERN_MAX + 1);
  localparam int unsigned IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned SW     = (POSITION_BITS > dds_pkg::OUT_W) ? POSITION_BITS
                                                                    : dds_pkg::OUT_W;

  logic [LEN_W-1:0]               len_q;
  logic [dds_pkg::MASKS_W-1:0]    masks_q;
  logic [dds_pkg::BASE_W-1:0]     win_q [PATTERN_MAX];
  logic [dds_pkg::BASE_W-1:0]     win_d [PATTERN_MAX];
  logic [FILL_W-1:0]              fill_q, fill_d;
  logic [POSITION_BITS-1:0]       pos_q, pos_cur, start_pos;
  logic [SW-1:0]                  start_ext;
  logic [LEN_W-1:0]               len_eff;
  logic                           match;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    priority if (len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_q > LEN_W'(PATTERN_MAX)) begin
      len_eff = LEN_W'(PATTERN_MAX);
    end else begin
      len_eff = len_q;
    end
  end

  always_comb begin
    win_d[0] = in_i.base;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      win_d[j] = in_i.restart ? '0 : win_q[j-1];
    end
    if (in_i.restart) begin
      fill_d = FILL_W'(1);
    end else if (fill_q < FILL_W'(PATTERN_MAX)) begin
      fill_d = fill_q + FILL_W'(1);
    end else begin
      fill_d = fill_q;
    end
  end

  // pattern position i lines up with the base len-1-i steps back
  always_comb begin
    logic [LEN_W-1:0]           k;
    logic [dds_pkg::MASK_W-1:0] nib;
    match = (LEN_W'(fill_d) >= len_eff);
    for (int i = 0; i < PATTERN_MAX; i++) begin
      k   = len_eff - LEN_W'(1) - LEN_W'(i);
      nib = masks_q[i*dds_pkg::MASK_W +: dds_pkg::MASK_W];
      if ((LEN_W'(i) < len_eff) && !nib[win_d[k[IDX_W-1:0]]]) begin
        match = 1'b0;
      end
    end
  end

  assign pos_cur   = in_i.restart ? '0 : pos_q;
  assign start_pos = pos_cur - POSITION_BITS'(len_eff - LEN_W'(1));
  assign start_ext = SW'(start_pos);

  assign push_data_o.hit        = match;
  assign push_data_o.site_start = match ? start_ext[dds_pkg::OUT_W-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= LEN_W'(1);
      masks_q <= '0;
    end else if (cfg_we_i) begin
      unique case (dds_pkg::cfg_idx_e'(cfg_idx_i))
        dds_pkg::CFG_PATTERN_LENGTH: len_q   <= cfg_data_i[LEN_W-1:0];
        dds_pkg::CFG_PATTERN_MASKS:  masks_q <= cfg_data_i[dds_pkg::MASKS_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pos_q  <= '0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
        win_q[j] <= '0;
      end
    end else if (push_o) begin
      fill_q <= fill_d;
      pos_q  <= pos_cur + POSITION_BITS'(1);
      for (int j = 0; j < PATTERN_MAX; j++) begin
        win_q[j] <= win_d[j];
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/dds_queue.sv =====
// Short queue between front and back end of the site scanner.
// Depends on dds_pkg.
`default_nettype none
module dds_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  dds_pkg::match_t        push_data_i,
  input  wire logic              pop_i,
  output dds_pkg::match_t        pop_data_o,
  output dds_pkg::queue_status_t status_o
);
  localparam int unsigned DEPTH = dds_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dds_pkg::match_t  mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // depth is a power of two, pointers wrap naturally
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/dds_back.sv =====
// Back end: match numbering and output register of the site scanner.
// Depends on dds_pkg and dds_if.
`default_nettype none
module dds_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  dds_pkg::queue_status_t status_i,
  input  dds_pkg::match_t        pop_data_i,
  output logic                   pop_o,
  dds_out_if.source              out_o
);
  localparam int unsigned OUT_W = dds_pkg::OUT_W;

  logic             valid_q;
  logic             hit_q;
  logic [OUT_W-1:0] start_q, index_q, count_q;

  assign pop_o = !status_i.empty && (!valid_q || out_o.ready);

  assign out_o.valid      = valid_q;
  assign out_o.hit        = hit_q;
  assign out_o.site_start = start_q;
  assign out_o.hit_index  = index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      count_q <= '0;
    end else begin
      if (pop_o) begin
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
      if (pop_o && pop_data_i.hit) begin
        count_q <= count_q + OUT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      hit_q   <= pop_data_i.hit;
      start_q <= pop_data_i.site_start;
      index_q <= pop_data_i.hit ? count_q : '0;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/degenerate_dna_site_scanner.sv =====
// Path: the result of an accepted base is written into the queue, then popped into the output register on out_o.
// Throughput: one base per cycle; the output register and two-entry queue
// absorb output stalls, the input stalls only once the queue is full.
// Reset: window, fill count, position and match count cleared; pattern length 1,
// all masks zero (nothing matches until configured).
`default_nettype none
`include "degenerate_dna_site_scanner_defines.svh"
module degenerate_dna_site_scanner #(
  parameter int unsigned PATTERN_MAX   = dds_pkg::PATTERN_MAX_DEF,
  parameter int unsigned POSITION_BITS = dds_pkg::POSITION_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [dds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [dds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  dds_in_if.sink                              in_i,
  dds_out_if.source                           out_o
);
  logic                   push, pop;
  dds_pkg::match_t        push_data, pop_data;
  dds_pkg::queue_status_t q_st;

  dds_front #(
    .PATTERN_MAX   (PATTERN_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .full_i      (q_st.full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  dds_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_st)
  );

  dds_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (q_st),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .out_o      (out_o)
  );

  `DDS_ASSERT_IMP(a_no_push_full, in_i.valid && in_i.ready, !q_st.full, "request taken while queue full")
  `DDS_ASSERT_IMP(a_no_pop_empty, pop, !q_st.empty, "pop from empty queue")
  `DDS_ASSERT_IMP(a_miss_zero, out_o.valid && !out_o.hit, (out_o.site_start == '0) && (out_o.hit_index == '0), "miss with nonzero fields")
  `DDS_ASSERT_NXT(a_drain, !q_st.empty && (!out_o.valid || out_o.ready), out_o.valid, "queued result not presented")
endmodule
`default_nettype wire
